FILE: rtl/core/infix_precedence_evaluator_defines.svh
// Assertion macros shared by the evaluator RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef INFIX_PRECEDENCE_EVALUATOR_DEFINES_SVH
`define INFIX_PRECEDENCE_EVALUATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// Check on every rising edge, muted while reset is active.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/ipe_pkg.sv
`default_nettype none

package ipe_pkg;

  // Token codes; the current operator also uses NONE, PLUS .. DIVIDE.
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_NUMBER = 3'd0;
  localparam logic [2:0] OP_PLUS   = 3'd1;
  localparam logic [2:0] OP_MINUS  = 3'd2;
  localparam logic [2:0] OP_TIMES  = 3'd3;
  localparam logic [2:0] OP_DIVIDE = 3'd4;
  localparam logic [2:0] OP_FINISH = 3'd5;

  // Pending additive operator: none, plus or minus.
  localparam logic [1:0] PEND_NONE = 2'd0;

  // Saturation limits of the signed 64-bit range.
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Partial products of the 64x64 multiply, 32x32 each.
  localparam int MUL_STEPS = 4;

  typedef struct packed {
    logic        start;
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
    logic        ovf;
    logic        dz;
  } unit_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/infix_precedence_evaluator.sv
// Number tokens and operators that need no arithmetic leave the block idle, so
// the next token is taken without a stall. Add/sub, multiply and divide steps
// run in the shared arithmetic unit (divide makes one quotient bit per cycle);
// an operator runs at most two steps, and finish adds an emit state for the result.
// Reset is asynchronous, active low, and clears all evaluation state at once.
`default_nettype none
`include "infix_precedence_evaluator_defines.svh"

module infix_precedence_evaluator #(
  parameter int FRACTION_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         in_operation_i,
  input  wire logic signed [63:0] in_operand_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [63:0]      out_total_o,
  output logic                    out_overflowed_o,
  output logic                    out_divided_by_zero_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP1,
    S_OP2,
    S_EMIT
  } eval_state_e;

  eval_state_e           state_q, state_d;
  logic [63:0]           latest_q, latest_d;
  logic [63:0]           held_q, held_d;
  logic [63:0]           running_q, running_d;
  logic [2:0]            cur_q, cur_d;
  logic [1:0]            pend_q, pend_d;
  logic                  ovf_q, ovf_d;
  logic                  dz_q, dz_d;
  logic                  need_add_q, need_add_d;
  logic                  fin_q, fin_d;
  logic                  out_valid_q, out_valid_d;
  logic [63:0]           out_total_q, out_total_d;
  logic                  out_ovf_q, out_ovf_d;
  logic                  out_dz_q, out_dz_d;
  ipe_pkg::unit_req_t    req_q, req_d;
  ipe_pkg::unit_status_t st;

  logic                  accept;
  logic                  fin;
  logic [2:0]            eff_op;
  logic                  additive;
  logic                  cur_mul;

  ipe_arith_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_q),
    .status_o(st)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Finish closes the expression as a plus would.
  always_comb begin
    fin      = (in_operation_i == ipe_pkg::OP_FINISH);
    eff_op   = fin ? ipe_pkg::OP_PLUS : in_operation_i;
    additive = (eff_op == ipe_pkg::OP_PLUS) || (eff_op == ipe_pkg::OP_MINUS);
    cur_mul  = (cur_q == ipe_pkg::OP_TIMES) || (cur_q == ipe_pkg::OP_DIVIDE);
  end

  // Sequence tokens through the shared unit.
  always_comb begin
    state_d     = state_q;
    latest_d    = latest_q;
    held_d      = held_q;
    running_d   = running_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    ovf_d       = ovf_q;
    dz_d        = dz_q;
    need_add_d  = need_add_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    out_total_d = out_total_q;
    out_ovf_d   = out_ovf_q;
    out_dz_d    = out_dz_q;
    req_d       = '0;

    // Drop the result once it is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_operation_i) inside
            ipe_pkg::OP_NUMBER: begin
              latest_d = $unsigned(in_operand_i);
            end
            ipe_pkg::OP_PLUS, ipe_pkg::OP_MINUS, ipe_pkg::OP_TIMES,
            ipe_pkg::OP_DIVIDE, ipe_pkg::OP_FINISH: begin
              latest_d = 64'd0;
              cur_d    = eff_op;
              fin_d    = fin;
              if (cur_q == ipe_pkg::OP_NONE) begin
                running_d = latest_q;
                state_d   = fin ? S_EMIT : S_IDLE;
              end else if (additive || (pend_q != ipe_pkg::PEND_NONE) || cur_mul) begin
                req_d.start = 1'b1;
                req_d.op    = cur_q;
                req_d.a     = running_q;
                req_d.b     = latest_q;
                need_add_d  = additive && (pend_q != ipe_pkg::PEND_NONE);
                state_d     = S_OP1;
              end else begin
                // Park the sum and start a product chain.
                held_d    = running_q;
                running_d = latest_q;
                pend_d    = cur_q[1:0];
                state_d   = fin ? S_EMIT : S_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OP1: begin
        if (st.done) begin
          running_d = st.value;
          ovf_d     = ovf_q | st.ovf;
          dz_d      = dz_q | st.dz;
          if (need_add_q) begin
            // Fold the product into the held sum.
            req_d.start = 1'b1;
            req_d.op    = {1'b0, pend_q};
            req_d.a     = held_q;
            req_d.b     = st.value;
            state_d     = S_OP2;
          end else begin
            state_d = fin_q ? S_EMIT : S_IDLE;
          end
        end
      end
      S_OP2: begin
        if (st.done) begin
          running_d = st.value;
          ovf_d     = ovf_q | st.ovf;
          dz_d      = dz_q | st.dz;
          pend_d    = ipe_pkg::PEND_NONE;
          state_d   = fin_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          // Emit the result beat and clear the expression.
          out_valid_d = 1'b1;
          out_total_d = running_q;
          out_ovf_d   = ovf_q;
          out_dz_d    = dz_q;
          latest_d    = 64'd0;
          held_d      = 64'd0;
          running_d   = 64'd0;
          cur_d       = ipe_pkg::OP_NONE;
          pend_d      = ipe_pkg::PEND_NONE;
          ovf_d       = 1'b0;
          dz_d        = 1'b0;
          need_add_d  = 1'b0;
          fin_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      latest_q    <= 64'd0;
      held_q      <= 64'd0;
      running_q   <= 64'd0;
      cur_q       <= ipe_pkg::OP_NONE;
      pend_q      <= ipe_pkg::PEND_NONE;
      ovf_q       <= 1'b0;
      dz_q        <= 1'b0;
      need_add_q  <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_total_q <= 64'd0;
      out_ovf_q   <= 1'b0;
      out_dz_q    <= 1'b0;
      req_q       <= '0;
    end else begin
      state_q     <= state_d;
      latest_q    <= latest_d;
      held_q      <= held_d;
      running_q   <= running_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      ovf_q       <= ovf_d;
      dz_q        <= dz_d;
      need_add_q  <= need_add_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      out_total_q <= out_total_d;
      out_ovf_q   <= out_ovf_d;
      out_dz_q    <= out_dz_d;
      req_q       <= req_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_total_o           = $signed(out_total_q);
  assign out_overflowed_o      = out_ovf_q;
  assign out_divided_by_zero_o = out_dz_q;

  `ASSERT_RST(a_req_in_op, clk_i, rst_ni,
              req_q.start |-> (state_q == S_OP1 || state_q == S_OP2),
              "unit request outside an operator step")
  `ASSERT_RST(a_pend_in_chain, clk_i, rst_ni,
              (state_q == S_IDLE && pend_q != ipe_pkg::PEND_NONE) |->
              (cur_q == ipe_pkg::OP_TIMES || cur_q == ipe_pkg::OP_DIVIDE),
              "pending sum outside a product chain")
  `ASSERT_RST(a_emit_clears, clk_i, rst_ni,
              (state_q == S_EMIT && !(out_valid_q && out_stall_i)) |=>
              (state_q == S_IDLE && cur_q == ipe_pkg::OP_NONE && out_valid_q),
              "emit did not clear the expression")

endmodule

`default_nettype wire

FILE: rtl/core/ipe_arith_unit.sv
`default_nettype none
`include "infix_precedence_evaluator_defines.svh"

// Shared arithmetic unit: saturating add/sub in one pass, multiply over four
// 32x32 partial products, restoring division one quotient bit per cycle.
module ipe_arith_unit #(
  parameter int FRACTION_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ipe_pkg::unit_req_t req_i,
  output ipe_pkg::unit_status_t   status_o
);

  localparam int NUM_W = 64 + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIN
  } unit_state_e;

  unit_state_e           state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  ipe_pkg::unit_status_t status_q, status_d;

  logic              neg_q, neg_d;
  logic [63:0]       x_q, x_d;
  logic [63:0]       y_q, y_d;
  logic [127:0]      acc_q, acc_d;
  logic [63:0]       prod_q, prod_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [63:0]       rem_q, rem_d;
  logic [127:0]      mag_q, mag_d;

  logic [63:0]       mag_a, mag_b;
  logic [64:0]       sum_w, dif_w;
  logic [31:0]       x_half, y_half;
  logic [127:0]      term, acc_sum;
  logic [63:0]       rem_sh;
  logic              rem_ge;
  logic [NUM_W-1:0]  num_sh;
  logic              mag_hi;

  // Form operand magnitudes and exact sums.
  always_comb begin
    mag_a = req_i.a[63] ? (64'd0 - req_i.a) : req_i.a;
    mag_b = req_i.b[63] ? (64'd0 - req_i.b) : req_i.b;
    sum_w = {req_i.a[63], req_i.a} + {req_i.b[63], req_i.b};
    dif_w = {req_i.a[63], req_i.a} - {req_i.b[63], req_i.b};
  end

  // Pick the halves and weight of the partial product.
  always_comb begin
    x_half = cnt_q[1] ? x_q[63:32] : x_q[31:0];
    y_half = cnt_q[0] ? y_q[63:32] : y_q[31:0];
    if (cnt_q == CNT_W'(1)) begin
      term = {64'd0, prod_q};
    end else if (cnt_q == CNT_W'(ipe_pkg::MUL_STEPS)) begin
      term = {prod_q, 64'd0};
    end else begin
      term = {32'd0, prod_q, 32'd0};
    end
    acc_sum = acc_q + term;
  end

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_q[62:0], num_q[NUM_W-1]};
    rem_ge = (rem_sh >= y_q);
    num_sh = {num_q[NUM_W-2:0], rem_ge};
    mag_hi = (mag_q[127:64] != 64'd0);
  end

  // Sequence the unit.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    status_d = '0;
    neg_d    = neg_q;
    x_d      = x_q;
    y_d      = y_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    num_d    = num_q;
    rem_d    = rem_q;
    mag_d    = mag_q;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.a[63] ^ req_i.b[63];
          x_d   = mag_a;
          y_d   = mag_b;
          cnt_d = '0;
          acc_d = '0;
          rem_d = '0;
          num_d = NUM_W'(mag_a) << FRACTION_BITS;
          case (req_i.op)
            ipe_pkg::OP_PLUS: begin
              status_d.done  = 1'b1;
              status_d.ovf   = sum_w[64] ^ sum_w[63];
              status_d.value = status_d.ovf ?
                               (req_i.a[63] ? ipe_pkg::VAL_MIN : ipe_pkg::VAL_MAX) :
                               sum_w[63:0];
            end
            ipe_pkg::OP_MINUS: begin
              status_d.done  = 1'b1;
              status_d.ovf   = dif_w[64] ^ dif_w[63];
              status_d.value = status_d.ovf ?
                               (req_i.a[63] ? ipe_pkg::VAL_MIN : ipe_pkg::VAL_MAX) :
                               dif_w[63:0];
            end
            ipe_pkg::OP_TIMES: begin
              state_d = U_MUL;
            end
            ipe_pkg::OP_DIVIDE: begin
              if (req_i.b == 64'd0) begin
                // Zero divisor: saturate by the dividend's sign; zero over zero gives zero.
                status_d.done = 1'b1;
                status_d.dz   = 1'b1;
                if (req_i.a == 64'd0) begin
                  status_d.value = 64'd0;
                end else begin
                  status_d.value = req_i.a[63] ? ipe_pkg::VAL_MIN : ipe_pkg::VAL_MAX;
                end
              end else begin
                state_d = U_DIV;
              end
            end
            default: begin
              status_d.done = 1'b1;
            end
          endcase
        end
      end
      U_MUL: begin
        prod_d = x_half * y_half;
        if (cnt_q != '0) begin
          acc_d = acc_sum;
        end
        if (cnt_q == CNT_W'(ipe_pkg::MUL_STEPS)) begin
          mag_d   = acc_sum >> FRACTION_BITS;
          state_d = U_FIN;
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      U_DIV: begin
        rem_d = rem_ge ? (rem_sh - y_q) : rem_sh;
        num_d = num_sh;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          mag_d   = 128'(num_sh);
          state_d = U_FIN;
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      U_FIN: begin
        // Apply the sign and saturate.
        status_d.done = 1'b1;
        if (neg_q) begin
          if (mag_hi || (mag_q[63:0] > ipe_pkg::VAL_MIN)) begin
            status_d.ovf   = 1'b1;
            status_d.value = ipe_pkg::VAL_MIN;
          end else begin
            status_d.value = 64'd0 - mag_q[63:0];
          end
        end else begin
          if (mag_hi || mag_q[63]) begin
            status_d.ovf   = 1'b1;
            status_d.value = ipe_pkg::VAL_MAX;
          end else begin
            status_d.value = mag_q[63:0];
          end
        end
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  // Hold state and the status beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= U_IDLE;
      cnt_q    <= '0;
      status_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  // Hold the datapath.
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    mag_q  <= mag_d;
  end

  assign status_o = status_q;

  `ASSERT_RST(a_start_idle, clk_i, rst_ni, req_i.start |-> (state_q == U_IDLE),
              "unit started while busy")
  `ASSERT_RST(a_dz_done, clk_i, rst_ni, status_q.dz |-> status_q.done,
              "zero-divide flag without done")
  `ASSERT_ALWAYS(a_dz_no_ovf, clk_i, status_q.dz |-> !status_q.ovf,
                 "zero divide also flagged overflow")

endmodule

`default_nettype wire

FILE: tb/infix_precedence_evaluator_checker.sv
`default_nettype none

module infix_precedence_evaluator_checker
  import ipe_pkg::*;
#(
  parameter int FRACTION_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  in_operation_i,
  input  wire logic [63:0] in_operand_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [63:0] out_total_i,
  input  wire logic        out_overflowed_i,
  input  wire logic        out_divided_by_zero_i,
  output int               fail_count_o,
  output int               results_due_o
);

  typedef struct packed {
    logic [63:0] total;
    logic        overflowed;
    logic        divided_by_zero;
  } evaluation_t;

  // Predicted evaluator state
  logic [63:0] latest   = '0;
  logic [63:0] held_sum = '0;
  logic [63:0] run_val  = '0;
  logic [2:0]  cur_op   = OP_NONE;
  logic [1:0]  pend_add = PEND_NONE;
  logic        sticky_ovf = 1'b0;
  logic        sticky_dz  = 1'b0;

  evaluation_t totals_due[$];
  int          mismatches = 0;

  initial begin
    fail_count_o  = 0;
    results_due_o = 0;
  end

  function automatic logic [63:0] magnitude(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  // Apply the sign to a wide magnitude and clamp to the 64-bit range
  function automatic logic [63:0] saturate(logic [127:0] mag, logic neg);
    if (neg) begin
      if (mag > 128'h8000_0000_0000_0000) begin
        sticky_ovf = 1'b1;
        return VAL_MIN;
      end
      return -mag[63:0];
    end
    if (mag > {64'd0, VAL_MAX}) begin
      sticky_ovf = 1'b1;
      return VAL_MAX;
    end
    return mag[63:0];
  endfunction

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sticky_ovf = 1'b1;
      return a[63] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] sub_clamped(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      sticky_ovf = 1'b1;
      return a[63] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] fx_times(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    return saturate(prod >> FRACTION_BITS, a[63] ^ b[63]);
  endfunction

  // Zero divisor saturates toward the dividend's sign (zero over zero gives zero) and raises its own flag
  function automatic logic [63:0] fx_divide(logic [63:0] a, logic [63:0] b);
    logic [127:0] quo;
    if (b == '0) begin
      sticky_dz = 1'b1;
      if (a == '0) return '0;
      return a[63] ? VAL_MIN : VAL_MAX;
    end
    quo = ({64'd0, magnitude(a)} << FRACTION_BITS) / {64'd0, magnitude(b)};
    return saturate(quo, a[63] ^ b[63]);
  endfunction

  function automatic logic [63:0] combine(logic [63:0] a, logic [2:0] op, logic [63:0] b);
    case (op)
      OP_PLUS:   return add_clamped(a, b);
      OP_MINUS:  return sub_clamped(a, b);
      OP_TIMES:  return fx_times(a, b);
      OP_DIVIDE: return fx_divide(a, b);
      default:   return '0;
    endcase
  endfunction

  // Close the operator in flight, honoring the two precedence levels
  function automatic void close_operator(logic [2:0] op);
    if (cur_op == OP_NONE) begin
      run_val = latest;
    end else if (op == OP_PLUS || op == OP_MINUS) begin
      run_val = combine(run_val, cur_op, latest);
      if (pend_add != PEND_NONE) begin
        run_val  = combine(held_sum, {1'b0, pend_add}, run_val);
        pend_add = PEND_NONE;
      end
    end else if (pend_add != PEND_NONE || cur_op >= OP_TIMES) begin
      run_val = combine(run_val, cur_op, latest);
    end else begin
      held_sum = run_val;
      run_val  = latest;
      pend_add = cur_op[1:0];
    end
    latest = '0;
    cur_op = op;
  endfunction

  function automatic void clear_evaluation();
    latest     = '0;
    held_sum   = '0;
    run_val    = '0;
    cur_op     = OP_NONE;
    pend_add   = PEND_NONE;
    sticky_ovf = 1'b0;
    sticky_dz  = 1'b0;
  endfunction

  function automatic void evaluate_token(logic [2:0] op, logic [63:0] operand);
    evaluation_t due;
    case (op)
      OP_NUMBER: begin
        latest = operand;
      end
      OP_PLUS, OP_MINUS, OP_TIMES, OP_DIVIDE: begin
        close_operator(op);
      end
      OP_FINISH: begin
        close_operator(OP_PLUS);
        due.total           = run_val;
        due.overflowed      = sticky_ovf;
        due.divided_by_zero = sticky_dz;
        totals_due.push_back(due);
        clear_evaluation();
      end
      default: ;
    endcase
  endfunction

  // Compare result beats first, then fold in the token beat of the same edge
  always @(posedge clk_i) begin : watch
    evaluation_t want;
    if (!rst_ni) begin
      clear_evaluation();
      totals_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (totals_due.size() == 0) begin
          $display("%0t: unexpected result: total %h ovf %b dz %b", $time,
                   out_total_i, out_overflowed_i, out_divided_by_zero_i);
          mismatches++;
        end else begin
          want = totals_due.pop_front();
          if (out_total_i !== want.total) begin
            $display("%0t: total mismatch: expected %h actual %h", $time,
                     want.total, out_total_i);
            mismatches++;
          end
          if (out_overflowed_i !== want.overflowed) begin
            $display("%0t: overflowed mismatch: expected %b actual %b", $time,
                     want.overflowed, out_overflowed_i);
            mismatches++;
          end
          if (out_divided_by_zero_i !== want.divided_by_zero) begin
            $display("%0t: divided_by_zero mismatch: expected %b actual %b", $time,
                     want.divided_by_zero, out_divided_by_zero_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        evaluate_token(in_operation_i, in_operand_i);
      end
    end
    fail_count_o  <= mismatches;
    results_due_o <= totals_due.size();
  end

endmodule

`default_nettype wire

FILE: tb/infix_precedence_evaluator_tb.sv
`default_nettype none

module infix_precedence_evaluator_tb;
  import ipe_pkg::*;

  localparam int FRACTION_BITS = 32;

  // Operation codes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [63:0] FX_ONE      = 64'h0000_0001_0000_0000;
  localparam logic [63:0] FX_ONE_HALF = 64'h0000_0001_8000_0000;

  localparam int TOKEN_TARGET = 1850;
  localparam int QUIET_FROM   = 1650;
  // A divide step, an add step and the emit state, with margin
  localparam int TAIL_CYCLES  = 250;
  localparam int TIMEOUT      = 18_000_000;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall_o;
  logic [2:0]         in_operation = OP_NUMBER;
  logic signed [63:0] in_operand   = '0;
  logic               out_valid_o;
  logic               out_stall    = 1'b0;
  logic signed [63:0] out_total_o;
  logic               out_overflowed_o;
  logic               out_divided_by_zero_o;

  int          fail_count;
  int          results_due;
  int          tokens_sent = 0;
  logic        gaps_on     = 1'b0;
  int unsigned stall_left  = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  infix_precedence_evaluator #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall_o),
    .in_operation_i        (in_operation),
    .in_operand_i          (in_operand),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall),
    .out_total_o           (out_total_o),
    .out_overflowed_o      (out_overflowed_o),
    .out_divided_by_zero_o (out_divided_by_zero_o)
  );

  infix_precedence_evaluator_checker #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall_o),
    .in_operation_i        (in_operation),
    .in_operand_i          (in_operand),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall),
    .out_total_i           (out_total_o),
    .out_overflowed_i      (out_overflowed_o),
    .out_divided_by_zero_i (out_divided_by_zero_o),
    .fail_count_o          (fail_count),
    .results_due_o         (results_due)
  );

  // Stall the result side in short random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [63:0] fixed_int(int k);
    return longint'(k) <<< FRACTION_BITS;
  endfunction

  // Mix of zero, range limits, small integers, fractions and raw bit patterns
  function automatic logic [63:0] pick_operand();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return 64'd1;
          default: return '1;
        endcase
      end
      2, 3:    return raw;
      4, 5:    return {{24{raw[39]}}, raw[39:0]};
      default: return fixed_int(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // Drive one beat and hold it until accepted
  task automatic send_token(input logic [2:0] op, input logic [63:0] val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_operand   <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op != OP_SPARE_LO && op != OP_SPARE_HI) tokens_sent++;
  endtask

  // Well-formed expression: number (operator number)* finish
  task automatic send_expression();
    int unsigned terms;
    terms = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
    send_token(OP_NUMBER, pick_operand());
    repeat (terms) begin
      send_token(3'($urandom_range(OP_PLUS, OP_DIVIDE)), {$urandom, $urandom});
      send_token(OP_NUMBER, pick_operand());
    end
    send_token(OP_FINISH, {$urandom, $urandom});
  endtask

  // Broken sequences: any code in any order, sometimes closed
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_token(3'($urandom_range(0, 7)), pick_operand());
    if ($urandom_range(0, 1) == 1) send_token(OP_FINISH, pick_operand());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Finish with nothing entered, then the ignored codes
    send_token(OP_FINISH, VAL_MAX);
    send_token(OP_SPARE_LO, VAL_MAX);
    send_token(OP_SPARE_HI, VAL_MIN);
    // Product overflow
    send_token(OP_NUMBER, VAL_MAX);
    send_token(OP_TIMES, '0);
    send_token(OP_NUMBER, VAL_MAX);
    send_token(OP_FINISH, '0);
    // Difference overflow at the negative limit
    send_token(OP_NUMBER, VAL_MIN);
    send_token(OP_MINUS, '0);
    send_token(OP_NUMBER, FX_ONE);
    send_token(OP_FINISH, '0);
    // Leading product chain ending in a zero divisor
    send_token(OP_NUMBER, fixed_int(-5));
    send_token(OP_TIMES, '1);
    send_token(OP_NUMBER, fixed_int(3));
    send_token(OP_DIVIDE, '1);
    send_token(OP_NUMBER, '0);
    send_token(OP_FINISH, '1);
    // Operator with no number, a replaced number, then mixed precedence
    send_token(OP_PLUS, VAL_MAX);
    send_token(OP_NUMBER, fixed_int(2));
    send_token(OP_NUMBER, fixed_int(-3));
    send_token(OP_TIMES, '0);
    send_token(OP_NUMBER, FX_ONE_HALF);
    send_token(OP_MINUS, '0);
    send_token(OP_NUMBER, 64'd1);
    send_token(OP_FINISH, '0);

    // Random expressions; no idling near the end
    while (tokens_sent < TOKEN_TARGET) begin
      gaps_on = (tokens_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        send_noise();
      end else begin
        send_expression();
      end
    end
    gaps_on = 1'b0;
    in_valid <= 1'b0;

    // Drain and let any stray result show up
    while (results_due != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
